>>> hdl/routing_table_prefix_lookup_defines.svh
// Assertion macros shared by the checker.
`ifndef ROUTING_TABLE_PREFIX_LOOKUP_DEFINES_SVH
`define ROUTING_TABLE_PREFIX_LOOKUP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RTPL_ASSERT_IMP(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RTPL_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> hdl/rtpl_pkg.sv
// ---------------------------------------------------------------------------
// rtpl_pkg
// Types and constants of the routing table prefix lookup block.
// ---------------------------------------------------------------------------
package rtpl_pkg;
  localparam int unsigned TableEntries = 16;

  localparam logic [2:0] OpAdd    = 3'd0;
  localparam logic [2:0] OpDelete = 3'd1;
  localparam logic [2:0] OpLookup = 3'd2;
  localparam logic [2:0] OpClear  = 3'd3;
  localparam logic [2:0] OpReadGw = 3'd4;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StDefault = 3'd1;
  localparam logic [2:0] StNoRoute = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StInvalid = 3'd4;

  localparam logic [1:0] KindNet     = 2'd0;
  localparam logic [1:0] KindHost    = 2'd1;
  localparam logic [1:0] KindDefault = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic        dst_given;
    logic [63:0] gw_high;
    logic [63:0] gw_low;
    logic        gw_given;
    logic [7:0]  iface;
    logic        iface_given;
  } req_t;

  typedef struct packed {
    logic [63:0] hop_high;
    logic [63:0] hop_low;
    logic [7:0]  iface_out;
    logic [2:0]  status;
  } rsp_t;

  // Compare result handed from the compare unit to the sequencer.
  typedef struct packed {
    logic       dst_eq;
    logic [4:0] len;
  } cmp_t;

  // Leading zero bytes of a 64-bit word, 0 to 8.
  function automatic logic [3:0] lead_bytes(input logic [63:0] x);
    logic [3:0] n;
    logic       stop;
    n = 4'd0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (!stop && x[63-8*b -: 8] == 8'd0) n = n + 4'd1;
      else stop = 1'b1;
    end
    return n;
  endfunction
endpackage

>>> hdl/routing_table_prefix_lookup.sv
// ---------------------------------------------------------------------------
// routing_table_prefix_lookup
// IPv6 routing table with add, delete, longest-prefix lookup, clear and read.
// ---------------------------------------------------------------------------
// Flow: add, clear and invalid transactions go from SFree straight to SOut; a read
// passes SRead and SFin; a delete scans the slots in SScan, then passes SFin; a
// lookup scans, then passes SFin and SHop. The scan uses the single compare unit,
// which visits one slot a cycle.
// Throughput: one transaction at a time; the next is accepted in the cycle after the
// result is taken. Reset empties the table and sets limit_q to 16.
module routing_table_prefix_lookup #(
  parameter int unsigned TABLE_ENTRIES = rtpl_pkg::TableEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rtpl_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rtpl_pkg::rsp_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [4:0]      cfg_data_i
);
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  // Sequencer states.
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SFree = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SRead = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;
  localparam logic [2:0] SOut  = 3'd5;
  localparam logic [2:0] SHop  = 3'd6;

  logic [2:0] state_q, state_d;
  rtpl_pkg::req_t req_q;
  logic [4:0] limit_q;

  // Slot storage is a memory read at one address per cycle, registered.
  logic [63:0] dh_mem [TABLE_ENTRIES];
  logic [63:0] dl_mem [TABLE_ENTRIES];
  logic [63:0] hh_mem [TABLE_ENTRIES];
  logic [63:0] hl_mem [TABLE_ENTRIES];
  logic [7:0]  if_mem [TABLE_ENTRIES];
  logic [1:0]  kd_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [IdxW-1:0] def_slot_q;
  logic            def_ok_q;
  logic [CntW-1:0] count_q;

  logic [IdxW-1:0] rd_addr;
  logic [63:0] rd_dh_q, rd_dl_q, rd_hh_q, rd_hl_q;
  logic [7:0]  rd_if_q;
  logic [1:0]  rd_kd_q;
  logic        rd_ok_q;        // read data belongs to a scanned slot
  logic [IdxW-1:0] rd_slot_q;

  logic [CntW-1:0] idx_q, idx_d;
  logic [4:0]      best_q;
  logic [IdxW-1:0] bslot_q;
  logic            removed_q;
  logic [CntW-1:0] nrem_q;
  logic            free_ok_q;
  logic [IdxW-1:0] free_slot_q;

  rtpl_pkg::rsp_t rsp_q;
  rtpl_pkg::cmp_t cmp;

  rtpl_cmp u_cmp (
    .a_high_i (rd_dh_q),
    .a_low_i  (rd_dl_q),
    .b_high_i (req_q.dst_high),
    .b_low_i  (req_q.dst_low),
    .cmp_o    (cmp)
  );

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = rsp_q;
  assign cfg_ready_o = 1'b1;

  // The compare unit sees the registered read of the slot addressed in the previous cycle.
  logic hit_del, hit_lkp;
  assign hit_del = rd_ok_q && valid_q[rd_slot_q] && cmp.dst_eq &&
                   (!req_q.iface_given || rd_if_q == req_q.iface);
  assign hit_lkp = rd_ok_q && valid_q[rd_slot_q] && (rd_kd_q != rtpl_pkg::KindDefault) &&
                   (rd_kd_q == rtpl_pkg::KindNet || cmp.len == 5'd16) &&
                   (cmp.len > best_q);

  logic [CntW-1:0] lim;
  assign lim = (32'(limit_q) > TABLE_ENTRIES) ? CntW'(TABLE_ENTRIES) : CntW'(limit_q);

  always_comb begin
    rd_addr = idx_q[IdxW-1:0];
    if (state_q == SFin) rd_addr = (req_q.operation == rtpl_pkg::OpLookup &&
                                    best_q == 5'd0) ? def_slot_q : bslot_q;
    if (state_q == SRead) rd_addr = def_slot_q;
  end

  always_ff @(posedge clk_i) begin
    rd_dh_q <= dh_mem[rd_addr];
    rd_dl_q <= dl_mem[rd_addr];
    rd_hh_q <= hh_mem[rd_addr];
    rd_hl_q <= hl_mem[rd_addr];
    rd_if_q <= if_mem[rd_addr];
    rd_kd_q <= kd_mem[rd_addr];
    rd_slot_q <= rd_addr;
    if (state_q == SFree && req_q.operation == rtpl_pkg::OpAdd && free_ok_q &&
        (req_q.dst_given || req_q.gw_given) && count_q < lim) begin
      hh_mem[free_slot_q] <= req_q.gw_given ? req_q.gw_high : req_q.dst_high;
      hl_mem[free_slot_q] <= req_q.gw_given ? req_q.gw_low : req_q.dst_low;
      if_mem[free_slot_q] <= req_q.iface_given ? req_q.iface : 8'd0;
      dh_mem[free_slot_q] <= req_q.dst_given ? req_q.dst_high : req_q.gw_high;
      dl_mem[free_slot_q] <= req_q.dst_given ? req_q.dst_low : req_q.gw_low;
      kd_mem[free_slot_q] <= !req_q.dst_given ? rtpl_pkg::KindDefault :
                             (req_q.dst_low == 64'd0) ? rtpl_pkg::KindNet :
                             rtpl_pkg::KindHost;
    end
  end

  // Lowest free slot, found from the valid bits.
  logic            fr_ok;
  logic [IdxW-1:0] fr_slot;
  always_comb begin
    fr_ok = 1'b0;
    fr_slot = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        fr_ok = 1'b1;
        fr_slot = IdxW'(i);
      end
    end
  end

  // First status of a transaction, settled in SFree.
  logic [2:0] st_free;
  always_comb begin
    st_free = rtpl_pkg::StInvalid;
    case (req_q.operation)
      rtpl_pkg::OpAdd: begin
        if (!req_q.dst_given && !req_q.gw_given) st_free = rtpl_pkg::StInvalid;
        else if (count_q >= lim || !free_ok_q) st_free = rtpl_pkg::StFull;
        else st_free = rtpl_pkg::StOk;
      end
      rtpl_pkg::OpDelete, rtpl_pkg::OpLookup:
        st_free = req_q.dst_given ? rtpl_pkg::StOk : rtpl_pkg::StInvalid;
      rtpl_pkg::OpClear, rtpl_pkg::OpReadGw: st_free = rtpl_pkg::StOk;
      default: st_free = rtpl_pkg::StInvalid;
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    case (state_q)
      SIdle: if (in_valid_i) begin
        state_d = SFree;
        idx_d = '0;
      end
      SFree: begin
        if ((req_q.operation == rtpl_pkg::OpLookup ||
             req_q.operation == rtpl_pkg::OpDelete) && req_q.dst_given) begin
          state_d = SScan;
          idx_d = idx_q + CntW'(1);
        end else if (req_q.operation == rtpl_pkg::OpReadGw) begin
          state_d = SRead;
        end else begin
          state_d = SOut;
        end
      end
      SScan: begin
        if (idx_q == CntW'(TABLE_ENTRIES)) state_d = SFin;
        else idx_d = idx_q + CntW'(1);
      end
      SRead: state_d = SFin;
      // A lookup passes through SHop to wait for the read of the chosen slot.
      SFin: state_d = (req_q.operation == rtpl_pkg::OpLookup) ? SHop : SOut;
      SHop: state_d = SOut;
      SOut: if (!out_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      limit_q <= 5'd16;
      valid_q <= '0;
      def_ok_q <= 1'b0;
      def_slot_q <= '0;
      count_q <= '0;
      idx_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
      rd_ok_q <= (state_q == SFree || state_q == SScan) &&
                 (idx_q < CntW'(TABLE_ENTRIES));
      if (state_q == SFree && req_q.operation == rtpl_pkg::OpAdd && free_ok_q &&
          (req_q.dst_given || req_q.gw_given) && count_q < lim) begin
        valid_q[free_slot_q] <= 1'b1;
        count_q <= count_q + CntW'(1);
        if (!req_q.dst_given) begin
          def_slot_q <= free_slot_q;
          def_ok_q <= 1'b1;
        end
      end
      if (state_q == SFree && req_q.operation == rtpl_pkg::OpClear) begin
        valid_q <= '0;
        count_q <= '0;
        def_ok_q <= 1'b0;
        def_slot_q <= '0;
      end
      if (req_q.operation == rtpl_pkg::OpDelete &&
          (state_q == SScan || state_q == SRead) && hit_del) begin
        valid_q[rd_slot_q] <= 1'b0;
        if (def_ok_q && def_slot_q == rd_slot_q) def_ok_q <= 1'b0;
      end
      if (state_q == SFin && req_q.operation == rtpl_pkg::OpDelete)
        count_q <= (count_q >= nrem_q) ? count_q - nrem_q : '0;
    end
  end

  // Lookup status once the scan is over.
  logic [2:0] lkp_st;
  assign lkp_st = (best_q != 5'd0) ? rtpl_pkg::StOk :
                  def_ok_q ? rtpl_pkg::StDefault : rtpl_pkg::StNoRoute;

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      req_q <= in_data_i;
      best_q <= 5'd0;
      bslot_q <= '0;
      removed_q <= 1'b0;
      nrem_q <= '0;
      free_ok_q <= fr_ok;
      free_slot_q <= fr_slot;
    end
    if (state_q == SScan) begin
      if (req_q.operation == rtpl_pkg::OpDelete && hit_del) begin
        removed_q <= 1'b1;
        nrem_q <= nrem_q + CntW'(1);
      end
      if (req_q.operation == rtpl_pkg::OpLookup && hit_lkp) begin
        best_q <= cmp.len;
        bslot_q <= rd_slot_q;
      end
    end
    if (state_q == SFree) begin
      rsp_q.hop_high <= 64'd0;
      rsp_q.hop_low <= 64'd0;
      rsp_q.iface_out <= 8'd0;
      rsp_q.status <= st_free;
    end
    if (state_q == SFin) begin
      case (req_q.operation)
        rtpl_pkg::OpDelete:
          rsp_q.status <= removed_q ? rtpl_pkg::StOk : rtpl_pkg::StNoRoute;
        rtpl_pkg::OpReadGw: begin
          if (def_ok_q) begin
            rsp_q.hop_high <= rd_dh_q;
            rsp_q.hop_low <= rd_dl_q;
            rsp_q.iface_out <= rd_if_q;
          end else begin
            rsp_q.iface_out <= 8'hFF;
            rsp_q.status <= rtpl_pkg::StNoRoute;
          end
        end
        default: ;
      endcase
    end
    // Lookup result: the read launched in SFin lands here.
    if (state_q == SHop) begin
      rsp_q.status <= lkp_st;
      rsp_q.hop_high <= (lkp_st == rtpl_pkg::StNoRoute) ? 64'd0 : rd_hh_q;
      rsp_q.hop_low <= (lkp_st == rtpl_pkg::StNoRoute) ? 64'd0 : rd_hl_q;
    end
  end
endmodule

>>> hdl/rtpl_cmp.sv
// ---------------------------------------------------------------------------
// rtpl_cmp
// Shared compare unit: common leading bytes and equality of two addresses.
// ---------------------------------------------------------------------------
module rtpl_cmp (
  input  logic [63:0]   a_high_i,
  input  logic [63:0]   a_low_i,
  input  logic [63:0]   b_high_i,
  input  logic [63:0]   b_low_i,
  output rtpl_pkg::cmp_t cmp_o
);
  logic [63:0] xh, xl;
  assign xh = a_high_i ^ b_high_i;
  assign xl = a_low_i ^ b_low_i;
  assign cmp_o.dst_eq = (xh == 64'd0) && (xl == 64'd0);
  // The count is 16 when all bytes match.
  assign cmp_o.len = (xh != 64'd0) ? {1'b0, rtpl_pkg::lead_bytes(xh)}
                                   : 5'd8 + {1'b0, rtpl_pkg::lead_bytes(xl)};
endmodule

>>> hdl/rtpl_checker.sv
// ---------------------------------------------------------------------------
// rtpl_checker
// Port-level checks of the routing table prefix lookup block.
// ---------------------------------------------------------------------------
`include "routing_table_prefix_lookup_defines.svh"
module rtpl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rtpl_pkg::rsp_t out_data_o
);
  // A transaction is never accepted while a result waits.
  `RTPL_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  // An accepted transaction blocks the input in the next cycle.
  `RTPL_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // A stalled result holds.
  `RTPL_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  // Status codes stay in range.
  `RTPL_ASSERT_IMP(a_status, clk_i, rst_ni, out_valid_o, out_data_o.status <= rtpl_pkg::StInvalid)
endmodule

bind routing_table_prefix_lookup rtpl_checker u_rtpl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
